### rtl/core/bankers_safety_checker_defines.svh
// Assertion macros shared by the safety checker RTL.
`ifndef BANKERS_SAFETY_CHECKER_DEFINES_SVH
`define BANKERS_SAFETY_CHECKER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bsc_pkg.sv
// Shared types and constants of the safety checker.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_ENTRY = 2'd0,
    OP_LOAD_TOTAL = 2'd1,
    OP_CHECK      = 2'd2,
    OP_REQUEST    = 2'd3
  } opcode_t;

  localparam logic KIND_SEQ     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int PIDX_W = 3;
  localparam int RIDX_W = 2;
  localparam int AMT_W  = 8;
  localparam int SEQ_W  = 3;

endpackage
`default_nettype wire

### rtl/core/bsc_if.sv
// Request and result channel interfaces of the safety checker.
`timescale 1ns / 1ps
`default_nettype none
interface bsc_req_if import bsc_pkg::*; ();
  logic              valid;
  logic              ready;
  opcode_t           opcode;
  logic [PIDX_W-1:0] process_index;
  logic [RIDX_W-1:0] resource_index;
  logic [AMT_W-1:0]  allocated_amount;
  logic [AMT_W-1:0]  maximum_amount;
  logic [AMT_W-1:0]  total_amount;
  logic [AMT_W-1:0]  request_amount;
  logic              last_element;

  modport source (
    output valid, opcode, process_index, resource_index, allocated_amount,
           maximum_amount, total_amount, request_amount, last_element,
    input  ready
  );
  modport sink (
    input  valid, opcode, process_index, resource_index, allocated_amount,
           maximum_amount, total_amount, request_amount, last_element,
    output ready
  );
endinterface

interface bsc_res_if import bsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [SEQ_W-1:0] sequence_process;
  logic             verdict;
  logic             last_result;

  modport source (
    output valid, result_kind, sequence_process, verdict, last_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, sequence_process, verdict, last_result,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/bankers_safety_checker.sv
// Banker's algorithm safety and request checker: tables, sequencer and scan lanes.
// Loads write a table entry or total directly; a request element reads its table row, then compares.
// A check first sums allocations over every row, then runs scan passes (up to PROCESSES
// passes, one table row compared per cycle on the shared lanes), then emits PROCESSES
// sequence entries and a verdict when safe.
// Reset clears control, finished flags and available vectors; tables hold no reset.
`timescale 1ns / 1ps
`default_nettype none
`include "bankers_safety_checker_defines.svh"
module bankers_safety_checker import bsc_pkg::*; #(
  parameter int PROCESSES = 8,
  parameter int RESOURCES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  bsc_req_if.sink   in_ch,
  bsc_res_if.source out_ch
);

  localparam int PW = $clog2(PROCESSES);
  localparam int CW = $clog2(PROCESSES + 1);
  localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int AW = $clog2(PROCESSES * 256) + 1;
  localparam int NW = AMT_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_REQ  = 5'b10000
  } state_t;

  typedef logic [RESOURCES-1:0][AMT_W-1:0] row_t;
  typedef logic [RESOURCES-1:0][AW-1:0]    avail_t;

  // Tables: one row per process, one lane per resource
  row_t alloc_mem [PROCESSES];
  row_t max_mem   [PROCESSES];
  row_t alloc_row_r;
  row_t max_row_r;
  row_t total_r;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     addr_r, addr_nxt;
  logic              iss_r, iss_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [PW-1:0]     cmp_p_r, cmp_p_nxt;
  logic              cmp_last_r, cmp_last_nxt;
  avail_t            work_r, work_nxt;
  avail_t            orig_r, orig_nxt;
  logic [PROCESSES-1:0] fin_r, fin_nxt;
  logic [CW-1:0]     released_r, released_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     emit_r, emit_nxt;
  logic [PW-1:0]     seq_r [PROCESSES];
  logic              request_ok_r, request_ok_nxt;

  logic              req_range_r, req_range_nxt;
  logic [RW-1:0]     req_res_r, req_res_nxt;
  logic [AMT_W-1:0]  req_amt_r, req_amt_nxt;
  logic              req_last_r, req_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]  out_proc_r, out_proc_nxt;
  logic              out_verdict_r, out_verdict_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              in_p_ok;
  logic              in_r_ok;
  logic [PW-1:0]     wr_p;
  logic [RW-1:0]     wr_r;
  logic [PW-1:0]     rd_addr;
  logic              out_free;
  logic              rel;
  logic              req_bad;
  logic              req_ok_now;
  logic [RESOURCES-1:0] lane_fit;
  logic signed [NW-1:0] need_s [RESOURCES];

  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_p_ok     = 32'(in_ch.process_index) < PROCESSES;
  assign in_r_ok     = 32'(in_ch.resource_index) < RESOURCES;
  assign wr_p        = PW'(in_ch.process_index);
  assign wr_r        = RW'(in_ch.resource_index);
  assign rd_addr     = (state_r == ST_IDLE) ? wr_p : addr_r;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_kind      = out_kind_r;
  assign out_ch.sequence_process = out_proc_r;
  assign out_ch.verdict          = out_verdict_r;
  assign out_ch.last_result      = out_last_r;

  // Table memories: lane write, registered row read
  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.opcode == OP_LOAD_ENTRY) && in_p_ok && in_r_ok) begin
      alloc_mem[wr_p][wr_r] <= in_ch.allocated_amount;
      max_mem[wr_p][wr_r]   <= in_ch.maximum_amount;
    end
    alloc_row_r <= alloc_mem[rd_addr];
    max_row_r   <= max_mem[rd_addr];
  end

  // Totals and the release order
  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.opcode == OP_LOAD_TOTAL) && in_r_ok) begin
      total_r[wr_r] <= in_ch.total_amount;
    end
    if (rel) begin
      seq_r[released_r[PW-1:0]] <= cmp_p_r;
    end
  end

  // Per-resource lanes: need and fit against the working vector
  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      need_s[r]   = $signed({1'b0, max_row_r[r]}) - $signed({1'b0, alloc_row_r[r]});
      lane_fit[r] = AW'(need_s[r]) <= $signed(work_r[r]);
    end
  end

  assign rel = (state_r == ST_SCAN) && cmp_v_r && !fin_r[cmp_p_r] && (&lane_fit);

  // Request element compare against need and the saved available vector
  always_comb begin
    req_bad = 1'b1;
    if (req_range_r) begin
      req_bad = ($signed({1'b0, req_amt_r}) > need_s[req_res_r]) ||
                ($signed(AW'({1'b0, req_amt_r})) > $signed(orig_r[req_res_r]));
    end
    req_ok_now = request_ok_r && !req_bad;
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    iss_nxt         = iss_r;
    work_nxt        = work_r;
    orig_nxt        = orig_r;
    fin_nxt         = fin_r;
    released_nxt    = released_r;
    found_nxt       = found_r;
    emit_nxt        = emit_r;
    request_ok_nxt  = request_ok_r;
    req_range_nxt   = req_range_r;
    req_res_nxt     = req_res_r;
    req_amt_nxt     = req_amt_r;
    req_last_nxt    = req_last_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_kind_nxt    = out_kind_r;
    out_proc_nxt    = out_proc_r;
    out_verdict_nxt = out_verdict_r;
    out_last_nxt    = out_last_r;

    // Advance the row read pipeline
    cmp_v_nxt    = iss_r;
    cmp_p_nxt    = addr_r;
    cmp_last_nxt = (addr_r == PW'(PROCESSES - 1));
    if (iss_r) begin
      addr_nxt = addr_r + 1'b1;
      iss_nxt  = !cmp_last_nxt;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.opcode)
            OP_CHECK: begin
              state_nxt = ST_SUM;
              addr_nxt  = '0;
              iss_nxt   = 1'b1;
              for (int r = 0; r < RESOURCES; r++) begin
                work_nxt[r] = AW'(total_r[r]);
              end
            end
            OP_REQUEST: begin
              state_nxt     = ST_REQ;
              req_range_nxt = in_p_ok && in_r_ok;
              req_res_nxt   = wr_r;
              req_amt_nxt   = in_ch.request_amount;
              req_last_nxt  = in_ch.last_element;
            end
            OP_LOAD_ENTRY, OP_LOAD_TOTAL: begin
              state_nxt = ST_IDLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SUM: begin
        if (cmp_v_r) begin
          for (int r = 0; r < RESOURCES; r++) begin
            work_nxt[r] = work_r[r] - AW'(alloc_row_r[r]);
          end
          if (cmp_last_r) begin
            orig_nxt     = work_nxt;
            state_nxt    = ST_SCAN;
            addr_nxt     = '0;
            iss_nxt      = 1'b1;
            fin_nxt      = '0;
            released_nxt = '0;
            found_nxt    = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (rel) begin
          for (int r = 0; r < RESOURCES; r++) begin
            work_nxt[r] = work_r[r] + AW'(alloc_row_r[r]);
          end
          fin_nxt[cmp_p_r] = 1'b1;
          released_nxt     = released_r + 1'b1;
          found_nxt        = 1'b1;
        end
        // Close the pass: all released, stalled, or go again
        if (cmp_v_r && cmp_last_r) begin
          priority if (released_nxt == CW'(PROCESSES)) begin
            state_nxt = ST_EMIT;
            emit_nxt  = '0;
          end else if (!found_nxt) begin
            state_nxt       = ST_IDLE;
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = KIND_VERDICT;
            out_proc_nxt    = '0;
            out_verdict_nxt = 1'b0;
            out_last_nxt    = 1'b1;
          end else begin
            addr_nxt  = '0;
            iss_nxt   = 1'b1;
            found_nxt = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (emit_r == CW'(PROCESSES)) begin
            state_nxt       = ST_IDLE;
            out_kind_nxt    = KIND_VERDICT;
            out_proc_nxt    = '0;
            out_verdict_nxt = 1'b1;
            out_last_nxt    = 1'b1;
          end else begin
            out_kind_nxt    = KIND_SEQ;
            out_proc_nxt    = SEQ_W'(seq_r[emit_r[PW-1:0]]);
            out_verdict_nxt = 1'b0;
            out_last_nxt    = 1'b0;
            emit_nxt        = emit_r + 1'b1;
          end
        end
      end
      ST_REQ: begin
        state_nxt = ST_IDLE;
        if (req_last_r) begin
          request_ok_nxt  = 1'b1;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_VERDICT;
          out_proc_nxt    = '0;
          out_verdict_nxt = req_ok_now;
          out_last_nxt    = 1'b1;
        end else begin
          request_ok_nxt = req_ok_now;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      addr_r       <= '0;
      iss_r        <= 1'b0;
      cmp_v_r      <= 1'b0;
      cmp_last_r   <= 1'b0;
      work_r       <= '0;
      orig_r       <= '0;
      fin_r        <= '0;
      released_r   <= '0;
      found_r      <= 1'b0;
      emit_r       <= '0;
      request_ok_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      iss_r        <= iss_nxt;
      cmp_v_r      <= cmp_v_nxt;
      cmp_last_r   <= cmp_last_nxt;
      work_r       <= work_nxt;
      orig_r       <= orig_nxt;
      fin_r        <= fin_nxt;
      released_r   <= released_nxt;
      found_r      <= found_nxt;
      emit_r       <= emit_nxt;
      request_ok_r <= request_ok_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmp_p_r       <= cmp_p_nxt;
    req_range_r   <= req_range_nxt;
    req_res_r     <= req_res_nxt;
    req_amt_r     <= req_amt_nxt;
    req_last_r    <= req_last_nxt;
    out_kind_r    <= out_kind_nxt;
    out_proc_r    <= out_proc_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Sequence entries come only from the result phase of a check
  `BSC_ASSERT_ALWAYS(a_seq_in_emit, !(out_valid_r && (out_kind_r == KIND_SEQ)) || (state_r == ST_EMIT), "sequence entry outside result phase")
  // The result phase is entered only with every process released
  `BSC_ASSERT_ALWAYS(a_emit_all_released, (state_r != ST_EMIT) || (released_r == CW'(PROCESSES)), "result phase without full release")
  // Release count never passes the process count
  `BSC_ASSERT_ALWAYS(a_released_bound, released_r <= CW'(PROCESSES), "release count overflow")
  // Saved available vector changes only at the end of the sum phase
  `BSC_ASSERT_NEXT(a_orig_hold, state_r == ST_IDLE, $stable(orig_r), "saved available changed while idle")

endmodule
`default_nettype wire
